[design/ricm_pkg.sv]
// Package for the rainbow intensity colormap unit.
// Holds the fixed-point constants and widths of the datapath; no dependencies.
`default_nettype none

package ricm_pkg;

	// Input intensity, unsigned Q1.12 with full scale 1.0 = 4096
	localparam int unsigned IntensityW = 13;
	localparam int unsigned ChanW      = 8;
	localparam logic [IntensityW-1:0] FullScale = 13'd4096;

	// Internal Q16 values
	localparam int unsigned HueW  = 19;  // (1-v)*14/3 in Q16, max 305834
	localparam int unsigned CompW = 16;  // component, max 0.75
	localparam int unsigned LiftW = 15;  // lift, max 26214
	localparam int unsigned SumW  = 17;  // component plus lift

	localparam logic [CompW-1:0] ChromaQ16 = 16'd49152;
	localparam logic [16:0]      OneQ16    = 17'd65536;
	localparam logic [LiftW-1:0] LiftBase  = 15'd11796;
	localparam logic [LiftW-1:0] LiftSlope = 15'd14418;

	// floor(u*224/3) = (u * 224 * ceil(2^21/3)) >> 21, exact for u*224 < 2^21
	localparam int unsigned HueShift = 21;
	localparam logic [27:0] HueRecip = 28'd156587424;

	localparam logic [ChanW-1:0] ChanMax  = 8'd255;
	localparam logic [ChanW-1:0] ChanMinC = 8'd46;  // lowest channel: lift base alone

	// Hue sectors
	typedef enum logic [2:0] {
		SEC_RED_YEL  = 3'd0,
		SEC_YEL_GRN  = 3'd1,
		SEC_GRN_CYN  = 3'd2,
		SEC_CYN_BLU  = 3'd3,
		SEC_BLU_MAG  = 3'd4
	} sector_t;

endpackage

`default_nettype wire

[design/rainbow_intensity_colormap_unit.sv]
// Rainbow intensity colormap: intensity (Q1.12) to 8-bit RGB along a hue sweep.
// Four-stage pipeline; uses ricm_pkg for constants and the sector type.
// A start transfer passes the stage 1, 2 and 3 valid registers and then the done register.
// Throughput: one item per cycle; busy is always low, the pipeline never stalls.
// Results appear on red/green/blue for exactly one cycle with done high.
// Reset: arst_n asynchronously clears the stage valid bits; payload is not reset.
`default_nettype none

module rainbow_intensity_colormap_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [ricm_pkg::IntensityW-1:0]   intensity,
	output logic                                   done,
	output logic [ricm_pkg::ChanW-1:0]             red,
	output logic [ricm_pkg::ChanW-1:0]             green,
	output logic [ricm_pkg::ChanW-1:0]             blue
);
	import ricm_pkg::*;

	logic                  valid_s1, valid_s2, valid_s3;
	logic [IntensityW-1:0] v_s1;
	logic [HueW-1:0]       h_s2;
	logic [LiftW-1:0]      lift_s2, lift_s3;
	logic [CompW-1:0]      r_s3, g_s3, b_s3;

	logic                  accept;
	logic [IntensityW-1:0] v_sat;
	logic [IntensityW-1:0] v_inv;
	logic [40:0]           hue_prod;
	logic [26:0]           slope_prod;
	logic [LiftW-1:0]      lift_calc;
	logic [2:0]            sector;
	logic [15:0]           frac;
	logic [16:0]           mod2;
	logic [16:0]           tri_dist;
	logic [16:0]           one_minus_tri;
	logic [18:0]           x_times3;
	logic [CompW-1:0]      x_comp;
	logic [CompW-1:0]      r_sel, g_sel, b_sel;
	logic [ChanW-1:0]      red_calc, green_calc, blue_calc;

	// Never stall: a new transfer is taken every cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Saturate intensity above full scale
	assign v_sat = (intensity > FullScale) ? FullScale : intensity;

	// Stage 2 math: hue h = floor((1-v)*224/3) and lift = base + slope*v
	assign v_inv      = FullScale - v_s1;
	assign hue_prod   = 41'(v_inv) * 41'(HueRecip);
	assign slope_prod = 27'(LiftSlope) * 27'(v_s1);
	assign lift_calc  = LiftBase + LiftW'(slope_prod >> 12);

	// Stage 3 math: triangle term, x = 0.75*(1-tri), sector selection
	assign sector        = h_s2[HueW-1:16];
	assign frac          = h_s2[15:0];
	assign mod2          = {sector[0], frac};
	assign tri_dist      = (mod2 >= OneQ16) ? (mod2 - OneQ16) : (OneQ16 - mod2);
	assign one_minus_tri = OneQ16 - tri_dist;
	assign x_times3      = {2'b00, one_minus_tri} + {1'b0, one_minus_tri, 1'b0};
	assign x_comp        = CompW'(x_times3 >> 2);

	always_comb begin
		r_sel = '0;
		g_sel = '0;
		b_sel = '0;
		unique case (sector_t'(sector))
			SEC_RED_YEL: begin
				r_sel = ChromaQ16;
				g_sel = x_comp;
			end
			SEC_YEL_GRN: begin
				r_sel = x_comp;
				g_sel = ChromaQ16;
			end
			SEC_GRN_CYN: begin
				g_sel = ChromaQ16;
				b_sel = x_comp;
			end
			SEC_CYN_BLU: begin
				g_sel = x_comp;
				b_sel = ChromaQ16;
			end
			SEC_BLU_MAG: begin
				r_sel = x_comp;
				b_sel = ChromaQ16;
			end
			default: begin
				r_sel = ChromaQ16;
				b_sel = x_comp;
			end
		endcase
	end

	// Stage 4 math: scale by 255, round half up, clamp
	function automatic logic [ChanW-1:0] to_chan(input logic [CompW-1:0] comp,
			input logic [LiftW-1:0] lift);
		logic [SumW-1:0] sum;
		logic [25:0]     scaled;
		logic [9:0]      rounded;
		sum     = SumW'(comp) + SumW'(lift);
		scaled  = {1'b0, sum, 8'd0} - 26'(sum) + 26'd32768;
		rounded = scaled[25:16];
		to_chan = (rounded > 10'(ChanMax)) ? ChanMax : rounded[ChanW-1:0];
	endfunction

	assign red_calc   = to_chan(r_s3, lift_s3);
	assign green_calc = to_chan(g_s3, lift_s3);
	assign blue_calc  = to_chan(b_s3, lift_s3);

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done     <= valid_s3;
		end
	end

	// Hold payload per stage; load only on a valid item
	always_ff @(posedge clk) begin
		if (accept) begin
			v_s1 <= v_sat;
		end
		if (valid_s1) begin
			h_s2    <= hue_prod[HueShift +: HueW];
			lift_s2 <= lift_calc;
		end
		if (valid_s2) begin
			r_s3    <= r_sel;
			g_s3    <= g_sel;
			b_s3    <= b_sel;
			lift_s3 <= lift_s2;
		end
		if (valid_s3) begin
			red   <= red_calc;
			green <= green_calc;
			blue  <= blue_calc;
		end
	end

	// Every accepted transfer yields a result with done high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("result missing four cycles after transfer");

	// Hue never reaches the sixth sector after saturation
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (h_s2[HueW-1:16] <= 3'(SEC_BLU_MAG)))
		else $error("hue out of range");

	// One component is always zero
	a_one_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> ((r_s3 == '0) || (g_s3 == '0) || (b_s3 == '0)))
		else $error("no zero component");

	// Lift keeps every channel at or above its floor
	a_chan_floor: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((red >= ChanMinC) && (green >= ChanMinC) && (blue >= ChanMinC)))
		else $error("channel below lift floor");

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for rainbow_intensity_colormap_unit.
// Drives intensity samples through the start/busy transfer and checks each RGB result.
// Depends on ricm_pkg for port widths and the hue sector type.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ricm_pkg::*;

	// Fixed-point constants of the colormap, Q16 unless noted
	localparam int unsigned Q16_ONE     = 65536;
	localparam int unsigned Q16_HALF    = 32768;
	localparam int unsigned CHROMA      = 49152;
	localparam int unsigned LIFT_OFFSET = 11796;
	localparam int unsigned LIFT_GAIN   = 14418;
	localparam int unsigned HUE_NUM     = 224;
	localparam int unsigned HUE_DEN     = 3;
	localparam int unsigned LEVEL_MAX   = 255;
	localparam int unsigned FULL_LEVEL  = 4096;
	localparam int unsigned DRAIN_WAIT  = 12;

	typedef struct packed {
		logic [IntensityW-1:0] level;
		logic [ChanW-1:0]      red;
		logic [ChanW-1:0]      green;
		logic [ChanW-1:0]      blue;
	} color_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [IntensityW-1:0] intensity;
	logic                  done;
	logic [ChanW-1:0]      red;
	logic [ChanW-1:0]      green;
	logic [ChanW-1:0]      blue;

	color_t expected_colors[$];
	int     mismatches;
	int     colors_checked;
	int     levels_sent;
	int     levels_clipped;
	bit     back_to_back;

	rainbow_intensity_colormap_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.intensity (intensity),
		.done      (done),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Scale a Q16 component plus lift to 0..255, round half up, clamp
	function automatic logic [ChanW-1:0] scale_channel(input int unsigned comp,
			input int unsigned lift);
		longint unsigned scaled;
		scaled = ((longint'(comp) + lift) * LEVEL_MAX + Q16_HALF) >> 16;
		if (scaled > LEVEL_MAX)
			scaled = LEVEL_MAX;
		return scaled[ChanW-1:0];
	endfunction

	// Expected colour for one intensity sample
	function automatic color_t map_intensity_to_rgb(input logic [IntensityW-1:0] level);
		int unsigned     v;
		int unsigned     hue;
		int unsigned     frac;
		int unsigned     wrapped;
		int unsigned     tri_dist;
		int unsigned     side;
		int unsigned     lift;
		int unsigned     r_comp;
		int unsigned     g_comp;
		int unsigned     b_comp;
		longint unsigned prod;
		sector_t         sector;
		color_t          result;
		v = (level > FULL_LEVEL) ? FULL_LEVEL : int'(level);
		hue = ((FULL_LEVEL - v) * HUE_NUM) / HUE_DEN;
		sector = sector_t'(hue[18:16]);
		frac = hue & 32'hFFFF;
		// distance of the position within a two-sector pair from its middle
		wrapped = (hue[16] ? Q16_ONE : 0) + frac;
		tri_dist = (wrapped >= Q16_ONE) ? wrapped - Q16_ONE : Q16_ONE - wrapped;
		prod = longint'(CHROMA) * (Q16_ONE - tri_dist);
		side = int'(prod >> 16);
		r_comp = 0;
		g_comp = 0;
		b_comp = 0;
		case (sector)
			SEC_RED_YEL: begin
				r_comp = CHROMA;
				g_comp = side;
			end
			SEC_YEL_GRN: begin
				r_comp = side;
				g_comp = CHROMA;
			end
			SEC_GRN_CYN: begin
				g_comp = CHROMA;
				b_comp = side;
			end
			SEC_CYN_BLU: begin
				g_comp = side;
				b_comp = CHROMA;
			end
			SEC_BLU_MAG: begin
				r_comp = side;
				b_comp = CHROMA;
			end
			default: begin
				r_comp = CHROMA;
				b_comp = side;
			end
		endcase
		lift = LIFT_OFFSET + ((LIFT_GAIN * v) >> 12);
		result.level = level;
		result.red   = scale_channel(r_comp, lift);
		result.green = scale_channel(g_comp, lift);
		result.blue  = scale_channel(b_comp, lift);
		return result;
	endfunction

	// Print one mismatch line; keep the log short on a badly broken build
	task automatic report_mismatch(input string msg);
		if (mismatches < 100)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	// Idle cycles before the next transfer
	function automatic int draw_gap();
		if (back_to_back)
			return 0;
		if ($urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// Present one sample and hold it until the transfer happens
	task automatic send_level(input logic [IntensityW-1:0] level);
		int gap;
		gap = draw_gap();
		// idle with junk on the data port; it must be ignored
		repeat (gap) begin
			@(negedge clk);
			start     <= 1'b0;
			intensity <= IntensityW'($urandom);
		end
		@(negedge clk);
		start     <= 1'b1;
		intensity <= level;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		expected_colors.push_back(map_intensity_to_rgb(level));
		levels_sent++;
		if (level > FULL_LEVEL)
			levels_clipped++;
	endtask

	// Compare every result with the oldest expectation
	always @(posedge clk) begin
		color_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_colors.size() == 0) begin
				report_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d",
					red, green, blue));
			end else begin
				want = expected_colors.pop_front();
				colors_checked++;
				if (red !== want.red)
					report_mismatch($sformatf("level %0d red %0d, expected %0d",
						want.level, red, want.red));
				if (green !== want.green)
					report_mismatch($sformatf("level %0d green %0d, expected %0d",
						want.level, green, want.green));
				if (blue !== want.blue)
					report_mismatch($sformatf("level %0d blue %0d, expected %0d",
						want.level, blue, want.blue));
			end
		end
	end

	// Extremes, sector edges, clipping and bit patterns
	task automatic test_directed_edges();
		logic [IntensityW-1:0] edge_levels[$];
		edge_levels = '{13'd0, 13'd1, 13'd585, 13'd586, 13'd1462, 13'd1463,
			13'd2340, 13'd2341, 13'd2048, 13'd3218, 13'd3219, 13'd3700,
			13'd4095, 13'd4096, 13'd4097, 13'd8191, 13'h1555, 13'h0AAA,
			13'h1000, 13'h0FFF};
		foreach (edge_levels[i])
			send_level(edge_levels[i]);
	endtask

	// Random samples within full scale
	task automatic test_in_range(input int count);
		repeat (count)
			send_level(IntensityW'($urandom_range(0, FULL_LEVEL)));
	endtask

	// Random samples above full scale; they saturate to 1.0
	task automatic test_over_range(input int count);
		repeat (count)
			send_level(IntensityW'($urandom_range(FULL_LEVEL + 1, (1 << IntensityW) - 1)));
	endtask

	// Any 13-bit word
	task automatic test_full_word(input int count);
		repeat (count)
			send_level(IntensityW'($urandom));
	endtask

	// Transfers on consecutive cycles
	task automatic test_back_to_back(input int count);
		back_to_back = 1'b1;
		test_in_range(count);
		back_to_back = 1'b0;
	endtask

	// Stimulus
	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		intensity      = '0;
		mismatches     = 0;
		colors_checked = 0;
		levels_sent    = 0;
		levels_clipped = 0;
		back_to_back   = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_edges();
		test_in_range(280);
		test_back_to_back(100);
		test_in_range(280);
		test_over_range(80);
		test_full_word(90);

		@(negedge clk);
		start <= 1'b0;
		while (expected_colors.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d intensity samples (%0d above full scale), checked %0d colours.",
			levels_sent, levels_clipped, colors_checked);
		$display("Mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Timeout with %0d results outstanding", expected_colors.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
